FILE: rtl/core/i2cmbe_pkg.sv
`default_nettype none

package i2cmbe_pkg;

    localparam int PHASE_W = 10;
    localparam int RETRY_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;

    typedef logic [2:0] t_opcode;
    typedef logic [2:0] t_mode;
    typedef logic [7:0] t_byte;

    // Opcodes of the command field.
    localparam t_opcode OP_TICK  = 3'd0;
    localparam t_opcode OP_START = 3'd1;
    localparam t_opcode OP_STOP  = 3'd2;
    localparam t_opcode OP_WRITE = 3'd3;
    localparam t_opcode OP_READ  = 3'd4;
    localparam t_opcode OP_ADDR  = 3'd5;

    // Sequencer modes.
    localparam t_mode MODE_IDLE       = 3'd0;
    localparam t_mode MODE_START      = 3'd1;
    localparam t_mode MODE_STOP       = 3'd2;
    localparam t_mode MODE_WRITE      = 3'd3;
    localparam t_mode MODE_READ       = 3'd4;
    localparam t_mode MODE_ADDR_START = 3'd5;
    localparam t_mode MODE_ADDR_BYTE  = 3'd6;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 10'd4;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd10;

    localparam logic [3:0] ACK_BIT_IDX = 4'd8;
    localparam logic [3:0] TAIL_BIT_IDX = 4'd9;

endpackage

`default_nettype wire

FILE: rtl/core/i2cmbe_cmd_if.sv
`default_nettype none

interface i2cmbe_cmd_if;
    import i2cmbe_pkg::*;

    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_byte   data_byte;
    logic    send_nack;
    logic    sda_in;

    modport source (output valid, opcode, data_byte, send_nack, sda_in, input ready);
    modport sink (input valid, opcode, data_byte, send_nack, sda_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/i2cmbe_res_if.sv
`default_nettype none

interface i2cmbe_res_if;
    import i2cmbe_pkg::*;

    logic  valid;
    logic  ready;
    logic  scl_level;
    logic  sda_pull_low;
    logic  busy_res;
    logic  done_res;
    logic  nack_seen;
    t_byte read_byte;
    logic  rejected;

    modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, nack_seen,
                    read_byte, rejected, input ready);
    modport sink (input valid, scl_level, sda_pull_low, busy_res, done_res, nack_seen,
                  read_byte, rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/i2c_master_byte_engine.sv
`default_nettype none

// Channel    Direction  Contents
// i_cmd      in         opcode, data_byte, send_nack, sda_in (one item per tick)
// o_res      out        pin levels, busy, done, ack, read byte, rejected
// i_cfg_*    in         write port: phase_ticks (0), retry_limit (1)
//
// One item is accepted per cycle while the result is not stalled; each produces one result
// (input register, then the sequencer step into the result register).
// The sequencer state advances only when an item moves into the result register.
// A stalled result holds the sequencer and, once the input register is full, i_cmd.
// Reset is synchronous and active low; no clearing pass is needed.
module i2c_master_byte_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    i2cmbe_cmd_if.sink                             i_cmd,
    i2cmbe_res_if.source                           o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [i2cmbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [i2cmbe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import i2cmbe_pkg::*;

    logic [PHASE_W-1:0] r_phase_ticks;
    logic [RETRY_W-1:0] r_retry_limit;

    // Input register.
    logic    r_in_valid;
    t_opcode r_in_op;
    t_byte   r_in_data;
    logic    r_in_nack;
    logic    r_in_sda;

    // Sequencer state.
    t_mode              r_mode,    n_mode;
    logic [2:0]         r_sub,     n_sub;
    logic [PHASE_W-1:0] r_tick,    n_tick;
    logic [3:0]         r_bit,     n_bit;
    t_byte              r_shift,   n_shift;
    logic [RETRY_W-1:0] r_tries,   n_tries;
    logic               r_ack,     n_ack;
    logic               r_scl,     n_scl;
    logic               r_sda,     n_sda;
    logic               r_pnack,   n_pnack;
    t_byte              r_rx,      n_rx;
    logic               n_rej,     n_done;

    // Result register.
    logic  r_out_valid;
    logic  r_res_scl, r_res_sda, r_res_busy, r_res_done, r_res_ack, r_res_rej;
    t_byte r_res_rx;

    logic               step;
    logic [PHASE_W-1:0] plen;
    logic [PHASE_W:0]   tick_sum;

    assign step = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || step;
    assign plen = (r_phase_ticks == '0) ? PHASE_W'(1) : r_phase_ticks;

    always_comb begin
        n_mode  = r_mode;
        n_sub   = r_sub;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_tries = r_tries;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_pnack = r_pnack;
        n_rx    = r_rx;
        n_rej   = 1'b0;
        n_done  = 1'b0;
        tick_sum = '0;

        if (r_in_op inside {[OP_START:OP_ADDR]}) begin
            if (r_mode != MODE_IDLE) begin
                n_rej = 1'b1;
            end else begin
                n_sub  = '0;
                n_bit  = '0;
                n_tick = '0;
                case (r_in_op)
                    OP_START: n_mode = MODE_START;
                    OP_STOP:  n_mode = MODE_STOP;
                    OP_WRITE: begin
                        n_mode  = MODE_WRITE;
                        n_shift = r_in_data;
                    end
                    OP_READ: begin
                        n_mode  = MODE_READ;
                        n_shift = '0;
                        n_pnack = r_in_nack;
                    end
                    default: begin
                        n_mode  = MODE_ADDR_START;
                        n_shift = r_in_data;
                        n_tries = r_retry_limit;
                    end
                endcase
            end
        end

        if (n_mode != MODE_IDLE) begin
            // Pin levels for the current phase.
            case (n_mode)
                MODE_START, MODE_ADDR_START: begin
                    n_scl = (n_sub < 3'd2);
                    n_sda = (n_sub >= 3'd1);
                end
                MODE_STOP: begin
                    n_scl = (n_sub >= 3'd1);
                    n_sda = (n_sub < 3'd2);
                end
                default: begin
                    if (n_bit >= TAIL_BIT_IDX) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else begin
                        n_scl = n_sub[0];
                        if (n_mode == MODE_READ) begin
                            n_sda = (n_bit == ACK_BIT_IDX) ? !n_pnack : 1'b0;
                        end else if (n_bit < ACK_BIT_IDX) begin
                            n_sda = !n_shift[~n_bit[2:0]];
                        end else begin
                            n_sda = 1'b0;
                        end
                    end
                end
            endcase

            tick_sum = {1'b0, n_tick} + (PHASE_W+1)'(1);
            if (tick_sum >= {1'b0, plen}) begin
                n_tick = '0;
                // End of the phase.
                if (n_mode == MODE_START || n_mode == MODE_STOP ||
                    n_mode == MODE_ADDR_START) begin
                    if (n_sub < 3'd2) begin
                        n_sub = n_sub + 3'd1;
                    end else if (n_mode == MODE_ADDR_START) begin
                        n_mode = MODE_ADDR_BYTE;
                        n_sub  = '0;
                        n_bit  = '0;
                    end else begin
                        n_mode = MODE_IDLE;
                        n_done = 1'b1;
                    end
                end else if (n_bit >= TAIL_BIT_IDX) begin
                    if (n_mode == MODE_ADDR_BYTE && n_ack && n_tries > RETRY_W'(1)) begin
                        // Slave did not acknowledge: send start and address again.
                        n_tries = n_tries - RETRY_W'(1);
                        n_mode  = MODE_ADDR_START;
                    end else begin
                        if (n_mode == MODE_READ) begin
                            n_rx = n_shift;
                        end
                        n_mode = MODE_IDLE;
                        n_done = 1'b1;
                    end
                    n_sub = '0;
                    n_bit = '0;
                end else if (n_sub == 3'd0) begin
                    n_sub = 3'd1;
                end else begin
                    // Sample on the last tick of SCL high.
                    if (n_mode == MODE_READ) begin
                        if (n_bit < ACK_BIT_IDX) begin
                            n_shift = {n_shift[6:0], r_in_sda};
                        end
                    end else if (n_bit == ACK_BIT_IDX) begin
                        n_ack = r_in_sda;
                    end
                    n_sub = '0;
                    n_bit = n_bit + 4'd1;
                end
            end else begin
                n_tick = tick_sum[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_RESET;
            r_retry_limit <= RETRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_TICKS: r_phase_ticks <= i_cfg_data[PHASE_W-1:0];
                REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_op   <= i_cmd.opcode;
            r_in_data <= i_cmd.data_byte;
            r_in_nack <= i_cmd.send_nack;
            r_in_sda  <= i_cmd.sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_sub   <= '0;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_tries <= '0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b0;
            r_pnack <= 1'b0;
            r_rx    <= '0;
        end else if (step) begin
            r_mode  <= n_mode;
            r_sub   <= n_sub;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_tries <= n_tries;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_pnack <= n_pnack;
            r_rx    <= n_rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_res_scl  <= n_scl;
            r_res_sda  <= n_sda;
            r_res_busy <= (n_mode != MODE_IDLE);
            r_res_done <= n_done;
            r_res_ack  <= n_ack;
            r_res_rx   <= n_rx;
            r_res_rej  <= n_rej;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.scl_level    = r_res_scl;
    assign o_res.sda_pull_low = r_res_sda;
    assign o_res.busy_res     = r_res_busy;
    assign o_res.done_res     = r_res_done;
    assign o_res.nack_seen    = r_res_ack;
    assign o_res.read_byte    = r_res_rx;
    assign o_res.rejected     = r_res_rej;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res_done && r_res_busy))
        else $error("done and busy reported together");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_tick == '0))
        else $error("tick counter left running while idle");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub < 3'd3) && (r_bit <= TAIL_BIT_IDX))
        else $error("phase or bit counter out of range");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_rej) |-> (r_res_busy || r_res_done))
        else $error("command rejected while sequencer was idle");

    a_tick_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> (r_tick < plen))
        else $error("tick counter reached the phase length");
`endif

endmodule

`default_nettype wire

FILE: test/i2cmbe_tick_checker.sv
`timescale 1ns / 1ps

module i2cmbe_tick_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    i2cmbe_cmd_if                                  i_cmd_mon,
    i2cmbe_res_if                                  i_res_mon,
    input  wire logic                              i_cfg_we,
    input  wire logic [i2cmbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [i2cmbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned                            o_fail_count,
    output int unsigned                            o_pending,
    output logic                                   o_seq_busy
);
    import i2cmbe_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic  scl_level;
        logic  sda_pull_low;
        logic  busy_res;
        logic  done_res;
        logic  nack_seen;
        t_byte read_byte;
        logic  rejected;
    } t_pin_state;

    t_pin_state pin_states_due[$];
    int unsigned reports = 0;

    logic [PHASE_W-1:0] phase_ticks;
    logic [RETRY_W-1:0] retry_limit;

    t_mode        seq_mode;
    logic [2:0]   seq_step;
    int unsigned  tick_cnt;
    logic [3:0]   bit_no;
    t_byte        shifter;
    logic [7:0]   attempts_left;
    logic         ack_bit;
    logic         scl_q;
    logic         sda_low_q;
    logic         nack_to_send;
    t_byte        rx_byte;

    assign o_seq_busy = (seq_mode != MODE_IDLE);

    // Advances the sequencer by one tick and returns the pin state it shows afterwards.
    function automatic t_pin_state step_sequencer(input t_opcode op, input t_byte data,
                                                  input logic nack, input logic sda);
        t_pin_state r;
        int unsigned plen;
        r = '0;
        plen = (phase_ticks == '0) ? 1 : int'(phase_ticks);
        if (op >= OP_START && op <= OP_ADDR) begin
            if (seq_mode != MODE_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                seq_step = '0;
                bit_no = '0;
                tick_cnt = 0;
                case (op)
                    OP_START: seq_mode = MODE_START;
                    OP_STOP: seq_mode = MODE_STOP;
                    OP_WRITE: begin
                        seq_mode = MODE_WRITE;
                        shifter = data;
                    end
                    OP_READ: begin
                        seq_mode = MODE_READ;
                        shifter = '0;
                        nack_to_send = nack;
                    end
                    default: begin
                        seq_mode = MODE_ADDR_START;
                        shifter = data;
                        attempts_left = retry_limit;
                    end
                endcase
            end
        end

        if (seq_mode != MODE_IDLE) begin
            case (seq_mode)
                MODE_START, MODE_ADDR_START: begin
                    scl_q = (seq_step < 3'd2);
                    sda_low_q = (seq_step >= 3'd1);
                end
                MODE_STOP: begin
                    scl_q = (seq_step >= 3'd1);
                    sda_low_q = (seq_step < 3'd2);
                end
                default: begin
                    if (bit_no >= TAIL_BIT_IDX) begin
                        scl_q = 1'b0;
                        sda_low_q = 1'b0;
                    end else begin
                        scl_q = seq_step[0];
                        if (seq_mode == MODE_READ)
                            sda_low_q = (bit_no == ACK_BIT_IDX) ? !nack_to_send : 1'b0;
                        else if (bit_no < ACK_BIT_IDX)
                            sda_low_q = !shifter[3'd7 - bit_no[2:0]];
                        else
                            sda_low_q = 1'b0;
                    end
                end
            endcase

            tick_cnt++;
            if (tick_cnt >= plen) begin
                tick_cnt = 0;
                if (seq_mode == MODE_START || seq_mode == MODE_STOP ||
                    seq_mode == MODE_ADDR_START) begin
                    if (seq_step < 3'd2) begin
                        seq_step++;
                    end else if (seq_mode == MODE_ADDR_START) begin
                        seq_mode = MODE_ADDR_BYTE;
                        seq_step = '0;
                        bit_no = '0;
                    end else begin
                        seq_mode = MODE_IDLE;
                        r.done_res = 1'b1;
                    end
                end else if (bit_no >= TAIL_BIT_IDX) begin
                    // A NACKed address goes back to a fresh START while attempts remain.
                    if (seq_mode == MODE_ADDR_BYTE && ack_bit && attempts_left > 8'd1) begin
                        attempts_left--;
                        seq_mode = MODE_ADDR_START;
                    end else begin
                        if (seq_mode == MODE_READ)
                            rx_byte = shifter;
                        seq_mode = MODE_IDLE;
                        r.done_res = 1'b1;
                    end
                    seq_step = '0;
                    bit_no = '0;
                end else if (seq_step == '0) begin
                    seq_step = 3'd1;
                end else begin
                    // Bits are sampled at the end of the SCL-high half.
                    if (seq_mode == MODE_READ) begin
                        if (bit_no < ACK_BIT_IDX)
                            shifter = {shifter[6:0], sda};
                    end else if (bit_no == ACK_BIT_IDX) begin
                        ack_bit = sda;
                    end
                    seq_step = '0;
                    bit_no++;
                end
            end
        end

        r.scl_level = scl_q;
        r.sda_pull_low = sda_low_q;
        r.busy_res = (seq_mode != MODE_IDLE);
        r.nack_seen = ack_bit;
        r.read_byte = rx_byte;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_pin_state want;
        if (!i_rst_n) begin
            pin_states_due.delete();
            o_fail_count = 0;
            phase_ticks = PHASE_RESET;
            retry_limit = RETRY_RESET;
            seq_mode = MODE_IDLE;
            seq_step = '0;
            tick_cnt = 0;
            bit_no = '0;
            shifter = '0;
            attempts_left = '0;
            ack_bit = 1'b0;
            scl_q = 1'b1;
            sda_low_q = 1'b0;
            nack_to_send = 1'b0;
            rx_byte = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PHASE_TICKS)
                    phase_ticks = i_cfg_data[PHASE_W-1:0];
                else if (i_cfg_idx == REG_RETRY_LIMIT)
                    retry_limit = i_cfg_data[RETRY_W-1:0];
            end

            if (i_res_mon.valid && i_res_mon.ready) begin
                if (pin_states_due.size() == 0) begin
                    o_fail_count++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t: result item arrived with none expected", $time);
                    end
                end else begin
                    want = pin_states_due.pop_front();
                    check_field("scl_level", want.scl_level, i_res_mon.scl_level);
                    check_field("sda_pull_low", want.sda_pull_low, i_res_mon.sda_pull_low);
                    check_field("busy_res", want.busy_res, i_res_mon.busy_res);
                    check_field("done_res", want.done_res, i_res_mon.done_res);
                    check_field("nack_seen", want.nack_seen, i_res_mon.nack_seen);
                    check_field("read_byte", want.read_byte, i_res_mon.read_byte);
                    check_field("rejected", want.rejected, i_res_mon.rejected);
                end
            end

            if (i_cmd_mon.valid && i_cmd_mon.ready)
                pin_states_due.push_back(step_sequencer(i_cmd_mon.opcode, i_cmd_mon.data_byte,
                                                        i_cmd_mon.send_nack, i_cmd_mon.sda_in));
        end
        o_pending = pin_states_due.size();
    end

endmodule

FILE: test/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
    import i2cmbe_pkg::*;

    localparam t_opcode OP_SPARE_6 = 3'd6;
    localparam t_opcode OP_SPARE_7 = 3'd7;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum int { SLAVE_RANDOM, SLAVE_ABSENT, SLAVE_HOLDS_LOW } t_slave;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           fail_count;
    int unsigned           pending;
    logic                  seq_busy;
    int unsigned           holds_asked = 0;
    int unsigned           stall_cycles = 0;
    int unsigned           items_sent;
    int unsigned           burst_left;
    t_slave                slave;
    logic [RETRY_W-1:0]    retry_now;

    i2cmbe_cmd_if cmd_ch ();
    i2cmbe_res_if res_ch ();

    i2c_master_byte_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    i2cmbe_tick_checker tick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_res_mon    (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seq_busy   (seq_busy)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: runs of always-ready, light and heavy stalls, plus long hold-offs on request.
    initial begin : drain_results
        int unsigned holds_done;
        int stretch;
        int style;
        holds_done = 0;
        stretch = 0;
        style = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(4, 64);
                    style = $urandom_range(0, 2);
                end
                stretch--;
                case (style)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: res_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    function automatic logic line_level();
        case (slave)
            SLAVE_ABSENT: return 1'b1;
            SLAVE_HOLDS_LOW: return 1'b0;
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Offers one item and returns at the falling edge after it was taken.
    task automatic send_item(input t_opcode op, input t_byte data, input logic nack,
                             input logic sda);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        cmd_ch.opcode <= op;
        cmd_ch.data_byte <= data;
        cmd_ch.send_nack <= nack;
        cmd_ch.sda_in <= sda;
        cmd_ch.valid <= 1'b1;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Ticks until the sequencer is idle again; now and then a command arrives
    // mid-transfer and has to be turned away.
    task automatic finish_command();
        t_opcode op;
        while (seq_busy) begin
            op = ($urandom_range(0, 15) == 0) ? t_opcode'($urandom_range(OP_START, OP_SPARE_7))
                                              : OP_TICK;
            send_item(op, t_byte'($urandom), 1'($urandom), line_level());
        end
    endtask

    task automatic run_command(input t_opcode op, input t_byte data, input logic nack);
        send_item(op, data, nack, line_level());
        finish_command();
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        finish_command();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_RETRY_LIMIT)
            retry_now = value[RETRY_W-1:0];
    endtask

    // One bus transfer: address phase, a few data bytes and usually a STOP.
    task automatic run_transfer();
        t_byte addr;
        int nbytes;
        int pick;
        addr = $urandom;
        slave = (retry_now <= 8 && $urandom_range(0, 5) == 0) ? SLAVE_ABSENT : SLAVE_RANDOM;
        if ($urandom_range(0, 1)) begin
            run_command(OP_ADDR, addr, 1'($urandom));
        end else begin
            run_command(OP_START, t_byte'($urandom), 1'($urandom));
            run_command(OP_WRITE, addr, 1'($urandom));
        end
        nbytes = $urandom_range(0, 3);
        for (int i = 0; i < nbytes; i++) begin
            if (addr[0])
                run_command(OP_READ, t_byte'($urandom),
                            (i == nbytes - 1) ^ ($urandom_range(0, 7) == 0));
            else
                run_command(OP_WRITE, t_byte'($urandom), 1'($urandom));
        end
        // Sometimes the transfer is abandoned or disturbed by a stray command.
        case ($urandom_range(0, 9))
            0: ;
            1: run_command(t_opcode'($urandom_range(OP_TICK, OP_SPARE_7)), t_byte'($urandom),
                           1'($urandom));
            default: run_command(OP_STOP, t_byte'($urandom), 1'($urandom));
        endcase
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 3);
            send_item((pick == 0) ? OP_SPARE_6 : (pick == 1) ? OP_SPARE_7 : OP_TICK,
                      t_byte'($urandom), 1'($urandom), line_level());
        end
    endtask

    initial begin
        int unsigned base;
        int transfers;
        int knob;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_TICK;
        cmd_ch.data_byte = '0;
        cmd_ch.send_nack = 1'b0;
        cmd_ch.sda_in = 1'b1;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        burst_left = 0;
        items_sent = 0;
        slave = SLAVE_RANDOM;
        retry_now = RETRY_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: plain ticks, spare opcodes, every command at least once.
        send_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_item(OP_SPARE_6, 8'hFF, 1'b1, 1'b1);
        send_item(OP_SPARE_7, 8'hA5, 1'b0, 1'b1);
        send_item(OP_START, 8'h00, 1'b0, 1'b1);
        send_item(OP_STOP, 8'hFF, 1'b1, 1'b1);
        finish_command();
        slave = SLAVE_HOLDS_LOW;
        run_command(OP_WRITE, 8'hFF, 1'b0);
        slave = SLAVE_ABSENT;
        run_command(OP_WRITE, 8'h00, 1'b1);
        run_command(OP_READ, 8'h00, 1'b1);
        slave = SLAVE_HOLDS_LOW;
        run_command(OP_READ, 8'hFF, 1'b0);
        run_command(OP_ADDR, 8'hA1, 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0);

        // Zero in either register acts as one; with no slave the single attempt fails.
        set_reg(REG_PHASE_TICKS, '0);
        set_reg(REG_RETRY_LIMIT, '0);
        slave = SLAVE_ABSENT;
        run_command(OP_ADDR, 8'hFE, 1'b0);
        set_reg(REG_RETRY_LIMIT, 10'd3);
        run_command(OP_ADDR, 8'h43, 1'b1);
        run_command(OP_STOP, 8'h00, 1'b0);

        set_reg(REG_PHASE_TICKS, 10'd160);
        set_reg(REG_RETRY_LIMIT, 10'd255);
        slave = SLAVE_RANDOM;
        run_command(OP_START, 8'h00, 1'b0);
        set_reg(REG_PHASE_TICKS, 10'd1);
        run_command(OP_ADDR, t_byte'($urandom), 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0);

        base = items_sent;
        transfers = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (transfers % 4 == 0) begin
                knob = $urandom_range(0, 9);
                set_reg(REG_PHASE_TICKS, CFG_DATA_W'((knob == 0) ? 0 :
                                                     (knob < 3) ? $urandom_range(4, 9)
                                                                : $urandom_range(1, 3)));
                set_reg(REG_RETRY_LIMIT,
                        CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 255)
                                                                : $urandom_range(1, 4)));
            end
            if (transfers == 2 || transfers == 9)
                holds_asked <= holds_asked + 1;
            run_transfer();
            transfers++;
        end

        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_cmd_if.sv
rtl/core/i2cmbe_res_if.sv
rtl/core/i2c_master_byte_engine.sv
test/i2cmbe_tick_checker.sv
test/tb_i2c_master_byte_engine.sv
